// File: hdl/mf2d_pkg.sv
package mf2d_pkg;

    localparam int PIX_W  = 8;
    localparam int ROW_W  = 11;
    localparam int COL_W  = 11;
    localparam int CFG_W  = 12;
    localparam int IDX_W  = 2;
    localparam int TDATA_OUT_W = 32;

    localparam logic [IDX_W-1:0] REG_RADIUS = 2'd0;
    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd2;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } mf2d_meta_t;

    // rank of the median in a (2r+1)^2 window
    function automatic int median_rank(input int r);
        int n;
        begin
            n = 2 * r + 1;
            median_rank = (n * n) >> 1;
        end
    endfunction

endpackage

// File: hdl/mf2d_ram.sv
module mf2d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: hdl/mf2d_median.sv
module mf2d_median #(
    parameter int NW   = 9,
    parameter int CNTW = 4
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      en,
    input  logic                      in_valid,
    input  logic [NW*8-1:0]           in_vals,
    input  logic [NW-1:0]             in_mask,
    input  logic [CNTW-1:0]           in_k,
    input  mf2d_pkg::mf2d_meta_t      in_meta,
    output logic                      out_valid,
    output logic [7:0]                out_pixel,
    output mf2d_pkg::mf2d_meta_t      out_meta
);
    import mf2d_pkg::*;

    // radix select, one bit per stage from the MSB down
    logic [NW*8-1:0] v [0:8];
    logic [NW-1:0]   m [0:8];
    logic [CNTW-1:0] k [0:8];
    logic [7:0]      p [0:8];
    logic            vl [0:8];
    mf2d_meta_t      mt [0:8];

    assign v[0]  = in_vals;
    assign m[0]  = in_mask;
    assign k[0]  = in_k;
    assign p[0]  = '0;
    assign vl[0] = in_valid;
    assign mt[0] = in_meta;

    for (genvar g = 0; g < 8; g++)
    begin : g_stage
        localparam int B = 7 - g;
        logic [NW-1:0]   bits;
        logic [CNTW-1:0] cnt0;
        logic [NW*8-1:0] v_reg;
        logic [NW-1:0]   m_reg;
        logic [CNTW-1:0] k_reg;
        logic [7:0]      p_reg;
        logic            vl_reg;
        mf2d_meta_t      mt_reg;

        always_comb
        begin
            cnt0 = '0;
            for (int i = 0; i < NW; i++)
            begin
                bits[i] = v[g][i*8+B];
                cnt0 = cnt0 + CNTW'(m[g][i] & ~v[g][i*8+B]);
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vl_reg <= 1'b0;
            end
            else if (en)
            begin
                vl_reg <= vl[g];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg  <= v[g];
                mt_reg <= mt[g];
                if (k[g] < cnt0)
                begin
                    m_reg <= m[g] & ~bits;
                    k_reg <= k[g];
                    p_reg <= p[g];
                end
                else
                begin
                    m_reg    <= m[g] & bits;
                    k_reg    <= k[g] - cnt0;
                    p_reg    <= p[g] | (8'd1 << B);
                end
            end
        end

        assign v[g+1]  = v_reg;
        assign m[g+1]  = m_reg;
        assign k[g+1]  = k_reg;
        assign p[g+1]  = p_reg;
        assign vl[g+1] = vl_reg;
        assign mt[g+1] = mt_reg;
    end

    assign out_valid = vl[8];
    assign out_pixel = p[8];
    assign out_meta  = mt[8];

endmodule

// File: hdl/median_filter_2d_unit.sv
// Path from pixel request to result request: stage 1 register, m0 register, then the median stages.
// Throughput: one pixel per cycle; the line store RAM is read and written
// once per pixel, the median is an 8-stage bit-serial rank pipeline.
// Back-pressure on m_* stalls the whole pipeline.
// Reset: counters cleared, radius 1, 640x480; line store and window undefined.
module median_filter_2d_unit #(
    parameter int MAX_RADIUS = 3,
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // pixel
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mf2d_pkg::TDATA_OUT_W-1:0]  m_tdata,   // out_pixel, out_row, out_col, pad
    output logic                              m_tlast,   // last_of_frame
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mf2d_pkg::IDX_W-1:0]        cfg_index,
    input  logic [mf2d_pkg::CFG_W-1:0]        cfg_data
);
    import mf2d_pkg::*;

    localparam int WSIDE  = 2 * MAX_RADIUS + 1;
    localparam int NLINES = 2 * MAX_RADIUS;
    localparam int NW     = WSIDE * WSIDE;
    localparam int VW     = 8 * NLINES;
    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WW     = $clog2(MAX_WIDTH + 1);
    localparam int HW     = $clog2(MAX_HEIGHT + 1);
    localparam int RADW   = $clog2(MAX_RADIUS + 1);
    localparam int CNTW   = $clog2(NW + 1);

    logic [RADW-1:0] rad_reg;
    logic [WW-1:0]   w_reg;
    logic [HW-1:0]   h_reg;
    logic [CW-1:0]   col_reg;
    logic [RW-1:0]   row_reg;

    logic adv, acc, cfg_acc;
    logic [WW-1:0] col_p1;
    logic [HW-1:0] row_p1;
    logic emit;
    mf2d_meta_t meta;

    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv;
    assign acc      = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_acc  = cfg_valid && cfg_ready;

    assign col_p1 = WW'(col_reg) + WW'(1);
    assign row_p1 = HW'(row_reg) + HW'(1);
    assign emit   = (row_reg >= RW'({rad_reg, 1'b0})) && (col_reg >= CW'({rad_reg, 1'b0}));
    assign meta.row  = ROW_W'(row_reg - RW'(rad_reg));
    assign meta.col  = COL_W'(col_reg - CW'(rad_reg));
    assign meta.last = (col_p1 == w_reg) && (row_p1 == h_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rad_reg <= RADW'(1);
            w_reg   <= WW'(640);
            h_reg   <= HW'(480);
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (cfg_acc)
        begin
            case (cfg_index)
                REG_RADIUS:
                begin
                    rad_reg <= (cfg_data[1:0] > MAX_RADIUS) ? RADW'(MAX_RADIUS)
                                                             : RADW'(cfg_data[1:0]);
                end
                REG_WIDTH:
                begin
                    w_reg <= (cfg_data == '0) ? WW'(1) :
                             (cfg_data > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(cfg_data);
                end
                REG_HEIGHT:
                begin
                    h_reg <= (cfg_data == '0) ? HW'(1) :
                             (cfg_data > MAX_HEIGHT) ? HW'(MAX_HEIGHT) : HW'(cfg_data);
                end
                default:
                begin
                end
            endcase
            if (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)
            begin
                col_reg <= '0;
                row_reg <= '0;
            end
        end
        else if (acc)
        begin
            if (col_p1 == w_reg)
            begin
                col_reg <= '0;
                row_reg <= (row_p1 == h_reg) ? '0 : RW'(row_p1);
            end
            else
            begin
                col_reg <= CW'(col_p1);
            end
        end
    end

    // stage 1: column vector from the line store
    logic          s1_valid_reg, s1_emit_reg;
    logic [7:0]    s1_px_reg;
    logic [CW-1:0] s1_col_reg;
    mf2d_meta_t    s1_meta_reg;
    logic [VW-1:0] rdata, col_vec, new_vec, lw_vec_reg;
    logic          lw_valid_reg;
    logic [CW-1:0] lw_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            lw_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= acc;
            lw_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_px_reg   <= s_tdata;
            s1_col_reg  <= col_reg;
            s1_emit_reg <= emit;
            s1_meta_reg <= meta;
            lw_col_reg  <= s1_col_reg;
            lw_vec_reg  <= new_vec;
        end
    end

    // forward the previous write when it hit the same column
    assign col_vec = (lw_valid_reg && lw_col_reg == s1_col_reg) ? lw_vec_reg : rdata;
    if (NLINES > 1)
    begin : g_vec
        assign new_vec = {col_vec[VW-9:0], s1_px_reg};
    end
    else
    begin : g_vec1
        assign new_vec = s1_px_reg;
    end

    mf2d_ram #(
        .WIDTH (VW),
        .DEPTH (MAX_WIDTH)
    ) u_line (
        .clk   (clk),
        .we    (adv && s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (new_vec),
        .re    (adv),
        .raddr (col_reg),
        .rdata (rdata)
    );

    // window registers
    logic [7:0] win_reg  [WSIDE][WSIDE];
    logic [7:0] win_next [WSIDE][WSIDE];
    logic [NW*8-1:0] vals;
    logic [NW-1:0]   mask;
    int lo;

    always_comb
    begin
        lo = WSIDE - 1 - 2 * int'(rad_reg);
        for (int dy = 0; dy < WSIDE; dy++)
        begin
            for (int dx = 0; dx < WSIDE - 1; dx++)
            begin
                win_next[dy][dx] = win_reg[dy][dx+1];
            end
        end
        win_next[WSIDE-1][WSIDE-1] = s1_px_reg;
        for (int kk = 1; kk < WSIDE; kk++)
        begin
            win_next[WSIDE-1-kk][WSIDE-1] = col_vec[8*(kk-1) +: 8];
        end
        for (int dy = 0; dy < WSIDE; dy++)
        begin
            for (int dx = 0; dx < WSIDE; dx++)
            begin
                vals[(dy*WSIDE+dx)*8 +: 8] = win_next[dy][dx];
                mask[dy*WSIDE+dx] = (dy >= lo) && (dx >= lo);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            win_reg <= win_next;
        end
    end

    logic            m0_valid_reg;
    logic [NW*8-1:0] m0_vals_reg;
    logic [NW-1:0]   m0_mask_reg;
    logic [CNTW-1:0] m0_k_reg;
    mf2d_meta_t      m0_meta_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m0_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            m0_valid_reg <= s1_valid_reg && s1_emit_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            m0_vals_reg <= vals;
            m0_mask_reg <= mask;
            m0_k_reg    <= CNTW'(median_rank(int'(rad_reg)));
            m0_meta_reg <= s1_meta_reg;
        end
    end

    logic [7:0] med;
    mf2d_meta_t out_meta;

    mf2d_median #(
        .NW   (NW),
        .CNTW (CNTW)
    ) u_median (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (m0_valid_reg),
        .in_vals   (m0_vals_reg),
        .in_mask   (m0_mask_reg),
        .in_k      (m0_k_reg),
        .in_meta   (m0_meta_reg),
        .out_valid (m_tvalid),
        .out_pixel (med),
        .out_meta  (out_meta)
    );

    assign m_tdata = {2'b00, out_meta.col, out_meta.row, med};
    assign m_tlast = out_meta.last;

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready) else $error("input stalled with empty output");
    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        WW'(col_reg) < w_reg) else $error("column counter beyond width");
    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_acc && (cfg_index == REG_RADIUS || cfg_index == REG_WIDTH
                     || cfg_index == REG_HEIGHT)) |=> (col_reg == '0 && row_reg == '0))
        else $error("frame not restarted on config write");

endmodule

// File: dv/median_filter_2d_unit_test.sv
module median_filter_2d_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    import mf2d_pkg::*;

    localparam int MAX_R   = 3;
    localparam int MAX_W   = 2048;
    localparam int MAX_H   = 2048;
    localparam int SIDE    = 2 * MAX_R + 1;
    localparam int NLINE   = 2 * MAX_R;
    localparam int LAT     = 10;
    localparam logic [IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [PIX_W-1:0] px;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } median_out_t;

    class median_scoreboard;
        logic [7:0]     lines [NLINE][MAX_W];
        logic [7:0]     win [SIDE][SIDE];
        int unsigned    row_pos;
        int unsigned    col_pos;
        int unsigned    radius;
        int unsigned    width;
        int unsigned    height;
        median_out_t    medians_due [$];
        int             mismatches;

        function new();
            for (int i = 0; i < NLINE; i++)
                for (int j = 0; j < MAX_W; j++)
                    lines[i][j] = '0;
            for (int i = 0; i < SIDE; i++)
                for (int j = 0; j < SIDE; j++)
                    win[i][j] = '0;
            row_pos = 0;
            col_pos = 0;
            radius = 1;
            width = 640;
            height = 480;
            mismatches = 0;
        endfunction

        function void write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
            if (idx == REG_RADIUS)
                radius = 32'(val[1:0]);
            else if (idx == REG_WIDTH)
                width = 32'(val);
            else if (idx == REG_HEIGHT)
                height = 32'(val);
            else
                return;
            row_pos = 0;
            col_pos = 0;
        endfunction

        function int unsigned clamp_size(int unsigned v, int unsigned lim);
            if (v == 0)
                return 1;
            return (v > lim) ? lim : v;
        endfunction

        function logic [7:0] window_median(int unsigned r);
            int unsigned hist [256];
            int unsigned lo;
            int unsigned k;
            int unsigned acc;
            for (int i = 0; i < 256; i++)
                hist[i] = 0;
            lo = SIDE - 1 - 2 * r;
            for (int y = lo; y < SIDE; y++)
                for (int x = lo; x < SIDE; x++)
                    hist[win[y][x]]++;
            k = ((2 * r + 1) * (2 * r + 1)) / 2;
            acc = 0;
            for (int v = 0; v < 256; v++)
            begin
                acc += hist[v];
                if (acc > k)
                    return v[7:0];
            end
            return '0;
        endfunction

        function void note_pixel(logic [7:0] px);
            int unsigned r;
            int unsigned w;
            int unsigned h;
            int unsigned row;
            int unsigned col;
            median_out_t e;
            r = (radius > MAX_R) ? MAX_R : radius;
            w = clamp_size(width, MAX_W);
            h = clamp_size(height, MAX_H);
            row = (row_pos >= h) ? h - 1 : row_pos;
            col = (col_pos >= w) ? w - 1 : col_pos;
            for (int y = 0; y < SIDE; y++)
                for (int x = 0; x < SIDE - 1; x++)
                    win[y][x] = win[y][x + 1];
            win[SIDE - 1][SIDE - 1] = px;
            for (int k = 1; k < SIDE; k++)
                win[SIDE - 1 - k][SIDE - 1] =
                    (row >= k) ? lines[(row - k) % NLINE][col] : 8'd0;
            lines[row % NLINE][col] = px;
            if (row >= 2 * r && col >= 2 * r)
            begin
                e.px = window_median(r);
                e.row = ROW_W'(row - r);
                e.col = COL_W'(col - r);
                e.last = (row == h - 1 && col == w - 1);
                medians_due.push_back(e);
            end
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                    row = 0;
            end
            row_pos = row;
            col_pos = col;
        endfunction

        function void check_median(logic [TDATA_OUT_W-1:0] data, logic last);
            median_out_t e;
            median_out_t got;
            got.px = data[7:0];
            got.row = data[18:8];
            got.col = data[29:19];
            got.last = last;
            if (medians_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: px %0d row %0d col %0d last %0b",
                             got.px, got.row, got.col, got.last);
                return;
            end
            e = medians_due.pop_front();
            if (got.px !== e.px || got.row !== e.row || got.col !== e.col
                || got.last !== e.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"result mismatch: exp px %0d row %0d col %0d last %0b,",
                              " got px %0d row %0d col %0d last %0b"},
                             e.px, e.row, e.col, e.last,
                             got.px, got.row, got.col, got.last);
            end
        endfunction

        function int pending();
            return medians_due.size();
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [7:0]             s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [TDATA_OUT_W-1:0] m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [IDX_W-1:0]       cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    median_scoreboard sb;
    bit               src_gaps;
    bit               sink_stalls;
    int unsigned      pixels_sent;

    median_filter_2d_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // sink: random stall bursts, checks every accepted result
    initial
    begin
        int stall;
        stall = 0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall > 0)
                stall--;
            else if (sink_stalls && $urandom_range(0, 9) == 0)
                stall = $urandom_range(1, 11);
            m_tready = (stall == 0) && rst_n;
        end
    end

    always @(posedge clk)
        if (rst_n && m_tvalid && m_tready)
            sb.check_median(m_tdata, m_tlast);

    task automatic send_pixel(logic [7:0] px);
        if (src_gaps && $urandom_range(0, 9) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata = px;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_pixel(px);
        pixels_sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (LAT + 6) @(negedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_frame(int unsigned r, int unsigned w, int unsigned h);
        write_reg(REG_RADIUS, CFG_W'(r));
        write_reg(REG_WIDTH, CFG_W'(w));
        write_reg(REG_HEIGHT, CFG_W'(h));
    endtask

    function automatic logic [7:0] pick_pixel(int unsigned style);
        case (style)
            0: return 8'($urandom_range(0, 255));
            1: return 8'($urandom_range(0, 3) * 85);
            2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default: return 8'($urandom_range(120, 135));
        endcase
    endfunction

    task automatic run_frames(int unsigned npix);
        int unsigned style;
        style = $urandom_range(0, 3);
        for (int unsigned i = 0; i < npix; i++)
            send_pixel(pick_pixel(style));
    endtask

    initial
    begin
        int unsigned r;
        int unsigned w;
        int unsigned h;
        int unsigned wf;
        int unsigned hf;
        int unsigned n;
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        pixels_sent = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (3) @(negedge clk);

        // radius zero passes every pixel, extremes of the pixel field
        set_frame(0, 3, 2);
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h55);
        send_pixel(8'hAA);
        send_pixel(8'h01);
        send_pixel(8'h80);
        // 3x3 on a 3x3 image, one result flagged last
        set_frame(1, 3, 3);
        for (int i = 0; i < 9; i++)
            send_pixel((i % 2) ? 8'hFF : 8'h00);
        // image narrower than the window: nothing comes out
        set_frame(3, 6, 7);
        run_frames(6);
        // zero sizes act as one; unknown index is ignored
        write_reg(REG_UNUSED, 12'hFFF);
        set_frame(1, 0, 0);
        run_frames(3);

        while (pixels_sent < 1380)
        begin
            r = $urandom_range(0, 3);
            w = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : $urandom_range(2 * r + 1, 16);
            h = $urandom_range(0, 4) == 0 ? $urandom_range(0, 3) : $urandom_range(2 * r + 1, 10);
            set_frame(r, w, h);
            if ($urandom_range(0, 3) == 0)
                write_reg(REG_UNUSED, CFG_W'($urandom_range(0, 4095)));
            wf = (w == 0) ? 1 : w;
            hf = (h == 0) ? 1 : h;
            n = wf * hf * $urandom_range(1, 3);
            if ($urandom_range(0, 3) == 0)
                n = $urandom_range(1, n);
            run_frames(n);
        end

        // full-rate frames, no idling from here on
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        set_frame(3, 16, 7);
        run_frames(16 * 7);
        set_frame(0, 4, 12'hFFF);
        run_frames(40);
        set_frame(2, 5, 5);
        run_frames(5 * 5);

        drain();
        repeat (LAT * 2) @(negedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
